/* hw/rtl/assert_macros.svh */
// Assertion helpers; every use expects i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

/* hw/rtl/dmxtx_pkg.sv */
package dmxtx_pkg;

    // Default timing and capacity
    localparam int MAX_SLOTS_DEF     = 512;
    localparam int BIT_TICKS_DEF     = 4;
    localparam int BREAK_TICKS_DEF   = 100;
    localparam int MAB_TICKS_DEF     = 12;
    localparam int STOP_TICKS_DEF    = 8;
    localparam int TRAILER_TICKS_DEF = 20;

    // Phase tick counter width; covers every phase length up to 127
    localparam int TICK_W  = 7;
    localparam int COUNT_W = 10;
    localparam int INDEX_W = 9;
    localparam int CFG_W   = 32;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_SLOT   = 2'd1,
        MODE_HEADER = 2'd2,
        MODE_SELECT = 2'd3
    } t_mode;

    typedef enum logic {
        CFG_ENABLE   = 1'b0,
        CFG_INTERVAL = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_mode              mode;
        logic [1:0]         buffer;
        logic [INDEX_W-1:0] slot_index;
        logic [7:0]         data;
        logic [COUNT_W-1:0] slot_count;
    } t_in_item;

    typedef struct packed {
        logic        tx_line;
        logic        frame_busy;
        logic [31:0] frame_number;
        logic        active_buffer;
        logic        waiting_enable;
    } t_out_item;

endpackage

/* hw/rtl/dmxtx_ram.sv */
module dmxtx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/dmx512_frame_transmitter.sv */
// DMX512 frame transmitter, one input beat per microsecond tick or host write.
// Input channel (i_in_valid / o_in_stall / i_in_item): a beat is a time tick,
// a slot write, a header write (start code and slot count) or a buffer select.
// Every input beat yields exactly one output beat (o_out_valid / i_out_stall /
// o_out_item) carrying the line level, busy flag, frame number, active buffer
// and the waiting-for-enable flag as they stand after that beat.
// The result appears in the output register on the cycle after the input
// beat is taken. Throughput is one beat per cycle while the receiver does not
// stall; the whole update is a single pass through the state logic. A slot
// byte is read from the slot RAM on the tick that starts its start bit; it
// passes the RAM read register to the shift register before its first data bit.
// Configuration (i_cfg_we / i_cfg_index / i_cfg_data) writes enable or the
// frame interval; write it only while the block is idle.
// Reset clears all control state, both headers and the buffer selection; the
// line idles at mark, and the interval timer stays stopped until the first
// tick that sees enable. Slot RAM contents are undefined until written.
// When the receiver stalls, the pending result holds and o_in_stall rises,
// so no input beat is taken until the output beat drains.
module dmx512_frame_transmitter #(
    parameter int MAX_SLOTS     = dmxtx_pkg::MAX_SLOTS_DEF,
    parameter int BIT_TICKS     = dmxtx_pkg::BIT_TICKS_DEF,
    parameter int BREAK_TICKS   = dmxtx_pkg::BREAK_TICKS_DEF,
    parameter int MAB_TICKS     = dmxtx_pkg::MAB_TICKS_DEF,
    parameter int STOP_TICKS    = dmxtx_pkg::STOP_TICKS_DEF,
    parameter int TRAILER_TICKS = dmxtx_pkg::TRAILER_TICKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  dmxtx_pkg::t_in_item           i_in_item,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output dmxtx_pkg::t_out_item          o_out_item,
    input  logic                          i_cfg_we,
    input  dmxtx_pkg::t_cfg_index         i_cfg_index,
    input  logic [dmxtx_pkg::CFG_W-1:0]   i_cfg_data
);

    import dmxtx_pkg::*;
    `include "assert_macros.svh"

    localparam int SLOT_AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int RAM_AW  = SLOT_AW + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;

    localparam logic [COUNT_W-1:0] SLOT_LIM   = COUNT_W'(MAX_SLOTS);
    localparam logic [TICK_W-1:0]  BIT_LEN    = TICK_W'(BIT_TICKS);
    localparam logic [TICK_W-1:0]  BREAK_LEN  = TICK_W'(BREAK_TICKS);
    localparam logic [TICK_W-1:0]  MAB_LEN    = TICK_W'(MAB_TICKS);
    localparam logic [TICK_W-1:0]  STOP_LEN   = TICK_W'(STOP_TICKS);
    localparam logic [TICK_W-1:0]  TRAIL_LEN  = TICK_W'(TRAILER_TICKS);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BREAK,
        PH_MAB,
        PH_START,
        PH_SLOT,
        PH_TRAIL,
        PH_WAIT
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [TICK_W-1:0]  r_ticks, n_ticks;
    logic [3:0]         r_bitpos, n_bitpos;
    logic [7:0]         r_shift, n_shift;
    logic [COUNT_W-1:0] r_ptr, n_ptr;
    logic [31:0]        r_ivl_cnt, n_ivl_cnt;
    logic               r_pend, n_pend;
    logic               r_timer_on, n_timer_on;
    logic [31:0]        r_frame, n_frame;
    logic               r_cur, n_cur;
    logic               r_line, n_line;
    logic [1:0]         r_sel, n_sel;
    logic [7:0]         r_sc [2];
    logic [7:0]         n_sc [2];
    logic [COUNT_W-1:0] r_cnt [2];
    logic [COUNT_W-1:0] n_cnt [2];
    logic               r_load, n_load;
    logic               r_enable;
    logic [31:0]        r_interval;
    logic               r_out_valid;
    t_out_item          r_out_item, n_out_item;

    logic               acc;
    logic               ram_we;
    logic               ram_re;
    logic [RAM_AW-1:0]  ram_waddr;
    logic [RAM_AW-1:0]  ram_raddr;
    logic [7:0]         ram_rdata;

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign acc         = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign ram_we    = acc && (i_in_item.mode == MODE_SLOT) && !i_in_item.buffer[1]
                       && ({1'b0, i_in_item.slot_index} < SLOT_LIM);
    assign ram_waddr = {i_in_item.buffer[0], i_in_item.slot_index[SLOT_AW-1:0]};
    // The fetch address comes from registers: the tick that loads a slot
    // uses the pointer and buffer as they stood before it.
    assign ram_raddr = {r_cur, r_ptr[SLOT_AW-1:0]};

    dmxtx_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_item.data),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        logic [TICK_W-1:0] t;
        logic [TICK_W-1:0] len;
        logic [3:0]        bp;

        n_phase    = r_phase;
        n_ticks    = r_ticks;
        n_bitpos   = r_bitpos;
        n_shift    = r_shift;
        n_ptr      = r_ptr;
        n_ivl_cnt  = r_ivl_cnt;
        n_pend     = r_pend;
        n_timer_on = r_timer_on;
        n_frame    = r_frame;
        n_cur      = r_cur;
        n_line     = r_line;
        n_sel      = r_sel;
        n_sc       = r_sc;
        n_cnt      = r_cnt;
        n_load     = 1'b0;
        ram_re     = 1'b0;
        t          = '0;
        len        = BIT_LEN;
        bp         = '0;

        // Land the slot byte fetched on the previous cycle
        if (r_load) begin
            n_shift = ram_rdata;
        end

        if (acc) begin
            case (i_in_item.mode)
                MODE_TICK: begin
                    if (r_timer_on) begin
                        if (r_ivl_cnt == r_interval) begin
                            n_ivl_cnt = '0;
                            n_pend    = 1'b1;
                        end else begin
                            n_ivl_cnt = r_ivl_cnt + 32'd1;
                        end
                    end
                    if (n_phase == PH_WAIT && n_pend) begin
                        n_pend  = 1'b0;
                        n_phase = PH_IDLE;
                    end
                    if (n_phase == PH_IDLE && r_enable) begin
                        n_timer_on = 1'b1;
                        if (!r_sel[1]) begin
                            n_cur   = r_sel[0];
                            n_frame = r_frame + 32'd1;
                            n_ptr   = '0;
                            n_ticks = '0;
                            n_phase = PH_BREAK;
                        end
                    end
                    t = n_ticks + TICK_W'(1);
                    unique case (n_phase) inside
                        PH_IDLE, PH_WAIT: begin
                            n_line = 1'b1;
                        end
                        PH_BREAK: begin
                            n_line = 1'b0;
                            if (t >= BREAK_LEN) begin
                                n_ticks = '0;
                                n_phase = PH_MAB;
                            end else begin
                                n_ticks = t;
                            end
                        end
                        PH_MAB: begin
                            n_line = 1'b1;
                            if (t >= MAB_LEN) begin
                                n_shift  = r_sc[n_cur];
                                n_bitpos = '0;
                                n_ticks  = '0;
                                n_phase  = PH_START;
                            end else begin
                                n_ticks = t;
                            end
                        end
                        PH_TRAIL: begin
                            n_line = 1'b1;
                            if (t >= TRAIL_LEN) begin
                                n_ticks = '0;
                                n_phase = PH_WAIT;
                            end else begin
                                n_ticks = t;
                            end
                        end
                        PH_START, PH_SLOT: begin
                            if (n_bitpos == 4'd0) begin
                                n_line = 1'b0;
                                len    = BIT_LEN;
                            end else if (n_bitpos <= 4'd8) begin
                                n_line = n_shift[0];
                                len    = BIT_LEN;
                            end else begin
                                n_line = 1'b1;
                                len    = STOP_LEN;
                            end
                            if (t >= len) begin
                                n_ticks = '0;
                                if (n_bitpos >= 4'd1 && n_bitpos <= 4'd8) begin
                                    n_shift = n_shift >> 1;
                                end
                                bp = n_bitpos + 4'd1;
                                n_bitpos = bp;
                                if (bp > 4'd9) begin
                                    // Header count is live: re-read after every byte
                                    if (r_ptr < r_cnt[r_cur]) begin
                                        ram_re   = 1'b1;
                                        n_load   = 1'b1;
                                        n_ptr    = r_ptr + COUNT_W'(1);
                                        n_bitpos = '0;
                                        n_phase  = PH_SLOT;
                                    end else begin
                                        n_phase = (TRAILER_TICKS > 0) ? PH_TRAIL : PH_WAIT;
                                    end
                                end
                            end else begin
                                n_ticks = t;
                            end
                        end
                        default: begin
                            n_line = 1'b1;
                        end
                    endcase
                end
                MODE_HEADER: begin
                    if (!i_in_item.buffer[1]) begin
                        n_sc[i_in_item.buffer[0]]  = i_in_item.data;
                        n_cnt[i_in_item.buffer[0]] = (i_in_item.slot_count > SLOT_LIM)
                                                     ? SLOT_LIM : i_in_item.slot_count;
                    end
                end
                MODE_SELECT: begin
                    n_sel = i_in_item.buffer;
                end
                default: begin
                    // slot writes go straight to the RAM
                end
            endcase
        end

        n_out_item.tx_line        = n_line;
        n_out_item.frame_busy     = (n_phase != PH_IDLE);
        n_out_item.frame_number   = n_frame;
        n_out_item.active_buffer  = n_cur;
        n_out_item.waiting_enable = (n_phase == PH_IDLE) && !r_enable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_ticks     <= '0;
            r_bitpos    <= '0;
            r_shift     <= '0;
            r_ptr       <= '0;
            r_ivl_cnt   <= '0;
            r_pend      <= 1'b0;
            r_timer_on  <= 1'b0;
            r_frame     <= '0;
            r_cur       <= 1'b0;
            r_line      <= 1'b1;
            r_sel       <= '0;
            r_sc[0]     <= '0;
            r_sc[1]     <= '0;
            r_cnt[0]    <= '0;
            r_cnt[1]    <= '0;
            r_load      <= 1'b0;
            r_enable    <= 1'b0;
            r_interval  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_ticks    <= n_ticks;
            r_bitpos   <= n_bitpos;
            r_shift    <= n_shift;
            r_ptr      <= n_ptr;
            r_ivl_cnt  <= n_ivl_cnt;
            r_pend     <= n_pend;
            r_timer_on <= n_timer_on;
            r_frame    <= n_frame;
            r_cur      <= n_cur;
            r_line     <= n_line;
            r_sel      <= n_sel;
            r_sc       <= n_sc;
            r_cnt      <= n_cnt;
            r_load     <= n_load;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                    CFG_INTERVAL: r_interval <= i_cfg_data;
                    default:      r_enable   <= r_enable;
                endcase
            end
            // Hold the result while stalled; drop valid once the beat drains
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (acc) begin
            r_out_item <= n_out_item;
        end
    end

    `ASSERT_IMPLIES(a_load_at_slot_start, r_load,
        r_phase == PH_SLOT && r_bitpos == 4'd0, "slot fetch landed outside a slot start bit")
    `ASSERT_ALWAYS(a_ptr_in_range, r_ptr <= SLOT_LIM && r_cnt[0] <= SLOT_LIM
        && r_cnt[1] <= SLOT_LIM, "slot pointer or count beyond buffer size")
    `ASSERT_IMPLIES(a_idle_line_mark, r_out_valid && !r_out_item.frame_busy,
        r_out_item.tx_line, "line driven low while no frame is active")
    `ASSERT_IMPLIES(a_frame_starts_break, r_frame != $past(r_frame),
        r_phase == PH_BREAK, "frame count moved without entering break")

endmodule

/* tb/dmx512_frame_transmitter_tb.sv */
`timescale 1ns / 100ps

module dmx512_frame_transmitter_tb;
    import dmxtx_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RUN_LIMIT_NS = 10_000_000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BREAK,
        ST_MAB,
        ST_START,
        ST_SLOT,
        ST_TRAIL,
        ST_WAIT
    } line_phase_e;

    class dmx_scoreboard;
        logic [7:0]         slot_mem [1024];
        bit                 slot_seen [1024];
        logic [7:0]         start_code [2];
        logic [COUNT_W-1:0] slot_total [2];
        logic [1:0]         sel_buf;
        line_phase_e        ph;
        int unsigned        ph_ticks;
        int unsigned        bit_pos;
        logic [7:0]         shreg;
        logic [9:0]         slot_ptr;
        logic [31:0]        ivl_count;
        bit                 ivl_flag;
        logic [31:0]        frames;
        bit                 cur_buf;
        bit                 line;
        bit                 timer_run;
        bit                 en;
        logic [31:0]        ivl_limit;
        t_out_item          status_due [$];
        int                 errors;

        function new();
            for (int i = 0; i < 1024; i++) begin
                slot_mem[i]  = '0;
                slot_seen[i] = 1'b0;
            end
            for (int b = 0; b < 2; b++) begin
                start_code[b] = '0;
                slot_total[b] = '0;
            end
            sel_buf   = '0;
            ph        = ST_IDLE;
            ph_ticks  = 0;
            bit_pos   = 0;
            shreg     = '0;
            slot_ptr  = '0;
            ivl_count = '0;
            ivl_flag  = 1'b0;
            frames    = '0;
            cur_buf   = 1'b0;
            line      = 1'b1;
            timer_run = 1'b0;
            en        = 1'b0;
            ivl_limit = '0;
            errors    = 0;
        endfunction

        task report(input string what);
            if (errors < 30)
                $display("%0t ns  mismatch: %s", $time, what);
            errors++;
        endtask

        function void set_reg(input t_cfg_index idx, input logic [31:0] val);
            if (idx == CFG_ENABLE)
                en = val[0];
            else
                ivl_limit = val;
        endfunction

        // An interval below the running count would never be hit; shift it past the count.
        function logic [31:0] reachable(input logic [31:0] want);
            return (want >= ivl_count) ? want : ivl_count + want;
        endfunction

        // Slot that the running frame fetches next, if it still holds no data.
        function bit slot_due(output logic [9:0] addr);
            addr = {cur_buf, slot_ptr[8:0]};
            return (ph == ST_BREAK || ph == ST_MAB || ph == ST_START || ph == ST_SLOT)
                && slot_ptr < MAX_SLOTS_DEF && !slot_seen[addr];
        endfunction

        function void begin_byte(input logic [7:0] v, input line_phase_e p);
            shreg    = v;
            bit_pos  = 0;
            ph_ticks = 0;
            ph       = p;
        endfunction

        function void load_next_slot();
            if (slot_ptr < slot_total[cur_buf]) begin
                logic [9:0] a;
                a = {cur_buf, slot_ptr[8:0]};
                slot_ptr++;
                begin_byte(slot_mem[a], ST_SLOT);
            end else begin
                ph_ticks = 0;
                ph = (TRAILER_TICKS_DEF > 0) ? ST_TRAIL : ST_WAIT;
            end
        endfunction

        function bit drive_phase();
            bit          lvl;
            int unsigned len;
            ph_ticks++;
            case (ph)
                ST_BREAK: begin
                    lvl = 1'b0;
                    if (ph_ticks >= BREAK_TICKS_DEF) begin
                        ph_ticks = 0;
                        ph = ST_MAB;
                    end
                end
                ST_MAB: begin
                    lvl = 1'b1;
                    if (ph_ticks >= MAB_TICKS_DEF)
                        begin_byte(start_code[cur_buf], ST_START);
                end
                ST_TRAIL: begin
                    lvl = 1'b1;
                    if (ph_ticks >= TRAILER_TICKS_DEF) begin
                        ph_ticks = 0;
                        ph = ST_WAIT;
                    end
                end
                default: begin
                    if (bit_pos == 0) begin
                        lvl = 1'b0;
                        len = BIT_TICKS_DEF;
                    end else if (bit_pos <= 8) begin
                        lvl = shreg[0];
                        len = BIT_TICKS_DEF;
                    end else begin
                        lvl = 1'b1;
                        len = STOP_TICKS_DEF;
                    end
                    if (ph_ticks >= len) begin
                        ph_ticks = 0;
                        if (bit_pos >= 1 && bit_pos <= 8)
                            shreg = shreg >> 1;
                        bit_pos++;
                        if (bit_pos > 9)
                            load_next_slot();
                    end
                end
            endcase
            return lvl;
        endfunction

        function void advance_tick();
            if (timer_run) begin
                if (ivl_count == ivl_limit) begin
                    ivl_count = '0;
                    ivl_flag  = 1'b1;
                end else begin
                    ivl_count++;
                end
            end
            if (ph == ST_WAIT && ivl_flag) begin
                ivl_flag = 1'b0;
                ph = ST_IDLE;
            end
            // The tick that ends the wait may open the next break at once.
            if (ph == ST_IDLE && en) begin
                timer_run = 1'b1;
                if (sel_buf <= 2'd1) begin
                    cur_buf  = sel_buf[0];
                    frames++;
                    slot_ptr = '0;
                    ph_ticks = 0;
                    ph       = ST_BREAK;
                end
            end
            if (ph != ST_IDLE && ph != ST_WAIT)
                line = drive_phase();
            else
                line = 1'b1;
        endfunction

        function void note_beat(input t_in_item it);
            t_out_item st;
            case (it.mode)
                MODE_TICK: advance_tick();
                MODE_SLOT: begin
                    if (it.buffer <= 2'd1 && it.slot_index < MAX_SLOTS_DEF) begin
                        slot_mem[{it.buffer[0], it.slot_index}]  = it.data;
                        slot_seen[{it.buffer[0], it.slot_index}] = 1'b1;
                    end
                end
                MODE_HEADER: begin
                    if (it.buffer <= 2'd1) begin
                        start_code[it.buffer[0]] = it.data;
                        slot_total[it.buffer[0]] = (it.slot_count > MAX_SLOTS_DEF)
                            ? COUNT_W'(MAX_SLOTS_DEF) : it.slot_count;
                    end
                end
                default: sel_buf = it.buffer;
            endcase
            st.tx_line        = line;
            st.frame_busy     = (ph != ST_IDLE);
            st.frame_number   = frames;
            st.active_buffer  = cur_buf;
            st.waiting_enable = (ph == ST_IDLE) && !en;
            status_due.push_back(st);
        endfunction

        task check_status(input t_out_item got);
            t_out_item want;
            if (status_due.size() == 0) begin
                report("status beat with nothing due");
            end else begin
                want = status_due.pop_front();
                if (got.tx_line !== want.tx_line)
                    report($sformatf("tx_line %b, want %b", got.tx_line, want.tx_line));
                if (got.frame_busy !== want.frame_busy)
                    report($sformatf("frame_busy %b, want %b",
                        got.frame_busy, want.frame_busy));
                if (got.frame_number !== want.frame_number)
                    report($sformatf("frame_number %0d, want %0d",
                        got.frame_number, want.frame_number));
                if (got.active_buffer !== want.active_buffer)
                    report($sformatf("active_buffer %b, want %b",
                        got.active_buffer, want.active_buffer));
                if (got.waiting_enable !== want.waiting_enable)
                    report($sformatf("waiting_enable %b, want %b",
                        got.waiting_enable, want.waiting_enable));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        cfg_we = 1'b0;
    t_cfg_index  cfg_index = CFG_ENABLE;
    logic [31:0] cfg_data = '0;

    int gap_pct = 0;
    int stall_pct = 0;
    dmx_scoreboard sb;

    dmx512_frame_transmitter DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    always @(posedge clk) begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_status(out_item);
    end

    task automatic send_one(input t_in_item it);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_beat(it);
    endtask

    // Fill the slot a running frame will fetch next before the tick goes in.
    task automatic send(input t_in_item it);
        t_in_item   fill;
        logic [9:0] addr;
        if (it.mode == MODE_TICK && sb.slot_due(addr)) begin
            fill            = it;
            fill.mode       = MODE_SLOT;
            fill.buffer     = {1'b0, addr[9]};
            fill.slot_index = addr[8:0];
            fill.data       = 8'($urandom_range(255));
            send_one(fill);
        end
        send_one(it);
    endtask

    task automatic send_fields(input t_mode m, input logic [1:0] b, input logic [8:0] idx,
                               input logic [7:0] d, input logic [9:0] cnt);
        t_in_item it;
        it.mode       = m;
        it.buffer     = b;
        it.slot_index = idx;
        it.data       = d;
        it.slot_count = cnt;
        send(it);
    endtask

    // Hold off the sender until every status beat has drained.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.status_due.size() != 0);
    endtask

    task automatic set_regs(input bit en, input logic [31:0] ivl);
        logic [31:0] junk;
        junk = $urandom;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ENABLE;
        cfg_data  <= {junk[31:1], en};
        @(posedge clk);
        sb.set_reg(CFG_ENABLE, {junk[31:1], en});
        cfg_index <= CFG_INTERVAL;
        cfg_data  <= ivl;
        @(posedge clk);
        sb.set_reg(CFG_INTERVAL, ivl);
        cfg_we <= 1'b0;
    endtask

    function automatic t_in_item random_beat();
        t_in_item    it;
        int unsigned r;
        r             = $urandom_range(99);
        it.buffer     = 2'($urandom_range(3));
        it.slot_index = 9'($urandom_range(511));
        it.data       = 8'($urandom_range(255));
        it.slot_count = 10'($urandom_range(1023));
        if (r < 78) begin
            it.mode = MODE_TICK;
        end else if (r < 86) begin
            it.mode = MODE_SLOT;
            if ($urandom_range(3) != 0)
                it.slot_index = 9'($urandom_range(15));
            if ($urandom_range(4) != 0)
                it.buffer[1] = 1'b0;
        end else if (r < 93) begin
            it.mode = MODE_HEADER;
            // Keep frames short mostly; a long count gets cut by a later header.
            if ($urandom_range(19) != 0)
                it.slot_count = 10'($urandom_range(6));
            if ($urandom_range(4) != 0)
                it.buffer[1] = 1'b0;
        end else begin
            it.mode = MODE_SELECT;
            if ($urandom_range(4) != 0)
                it.buffer[1] = 1'b0;
        end
        return it;
    endfunction

    task automatic run_phase(input bit en, input logic [31:0] want, input int gap,
                             input int stall, input int beats);
        drain();
        set_regs(en, sb.reachable(want));
        gap_pct   = gap;
        stall_pct = stall;
        repeat (beats)
            send(random_beat());
    endtask

    initial begin
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset state, ignored targets, header saturation, every selection.
        send_fields(MODE_TICK,   2'd0, 9'd0,   8'h00, 10'd0);
        send_fields(MODE_HEADER, 2'd0, 9'd0,   8'h00, 10'd0);
        send_fields(MODE_HEADER, 2'd1, 9'd0,   8'hFF, 10'h3FF);
        send_fields(MODE_HEADER, 2'd2, 9'd0,   8'h55, 10'd3);
        send_fields(MODE_HEADER, 2'd3, 9'h1FF, 8'hAA, 10'd512);
        send_fields(MODE_SLOT,   2'd0, 9'd0,   8'hFF, 10'd0);
        send_fields(MODE_SLOT,   2'd1, 9'h1FF, 8'h00, 10'h3FF);
        send_fields(MODE_SLOT,   2'd1, 9'd0,   8'hA5, 10'd0);
        send_fields(MODE_SLOT,   2'd2, 9'd3,   8'h3C, 10'd0);
        send_fields(MODE_SLOT,   2'd3, 9'h100, 8'hC3, 10'd0);
        send_fields(MODE_SELECT, 2'd2, 9'd0,   8'h00, 10'd0);
        send_fields(MODE_SELECT, 2'd3, 9'd0,   8'h00, 10'd0);
        send_fields(MODE_SELECT, 2'd1, 9'd0,   8'h00, 10'd0);
        send_fields(MODE_TICK,   2'd3, 9'h1FF, 8'hFF, 10'h3FF);
        send_fields(MODE_HEADER, 2'd1, 9'd0,   8'h5A, 10'd1);
        send_fields(MODE_SELECT, 2'd3, 9'd0,   8'h00, 10'd0);
        drain();
        set_regs(1'b1, 32'd0);
        // No buffer selected: the timer starts but nothing goes out.
        send_fields(MODE_TICK,   2'd0, 9'd0,   8'h00, 10'd0);
        send_fields(MODE_TICK,   2'd0, 9'd0,   8'h00, 10'd0);
        send_fields(MODE_SELECT, 2'd0, 9'd0,   8'h00, 10'd0);
        send_fields(MODE_TICK,   2'd0, 9'd0,   8'h00, 10'd0);

        run_phase(1'b1, 32'd0,          0,  0,  350);
        run_phase(1'b1, 32'd3,          67, 0,  300);
        run_phase(1'b1, 32'd500,        0,  67, 300);
        run_phase(1'b0, 32'd500,        28, 28, 200);
        run_phase(1'b1, 32'hFFFF_FFFF,  0,  0,  200);
        run_phase(1'b1, 32'($urandom_range(20, 200)), 28, 28, 300);

        drain();
        stall_pct = 0;
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("timeout with %0d status beats outstanding", sb.status_due.size());
        $display("end of test: mismatches");
        $finish;
    end

endmodule
